/* rtl/core/lzw_byte_compressor_defines.svh */
// assertion macros for the lzw byte compressor
`ifndef LZW_BYTE_COMPRESSOR_DEFINES_SVH
`define LZW_BYTE_COMPRESSOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define LZWC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LZWC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define LZWC_ASSERT(label, clk, rst, prop, msg)
`define LZWC_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

/* rtl/core/lzwc_pkg.sv */
package lzwc_pkg;

   // fixed field widths
   localparam int BYTE_W = 8;
   localparam int CODE_OUT_W = 12;
   localparam int ROOT_CODES = 256;

   // first code that is learned; codes below stand for single bytes
   localparam int FIRST_LEARNED = 256;

   // request sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHILD,
      S_NODE,
      S_INSERT,
      S_EMIT,
      S_EMIT_LAST
   } lzwc_state_type;

endpackage

/* rtl/core/lzw_byte_compressor.sv */
// 12-bit LZW compressor over a byte stream.
// Request channel (req_valid/req_ready): one byte per request, with
// req_is_last_byte marking the final byte of a stream. Response channel
// (rsp_valid/rsp_ready): emitted codes, rsp_is_last_code on the code that
// closes the stream. A request yields zero, one or two responses.
// The dictionary is a trie in two RAMs (one write, one read port each): the
// first learned child of each code, and per learned code its byte and sibling.
// Per request: the first byte of a stream only loads the phrase; else the
// child RAM is read and the sibling list walked (up to 256 children, one
// node RAM read a cycle) to a hit or the end of the list; a miss learns the
// new node, links it and emits the phrase code. A full dictionary emits the
// phrase code and starts over; a last byte adds the closing code.
// Codes are loaded into a response register, so the block takes the next
// request while a code waits; when the receiver stalls and the register is
// still full, the sequencer holds in its emit state and req_ready stays low.
// Reset (synchronous, active high) empties the dictionary at once: no
// clearing pass. The end of a stream or a full dictionary does the same.
module lzw_byte_compressor
   import lzwc_pkg::*;
#(
   parameter int DICT_ENTRIES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  logic                  req_is_last_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CODE_OUT_W-1:0] rsp_out_code,
   output logic                  rsp_is_last_code
);

   localparam int CW = $clog2(DICT_ENTRIES);
   localparam int NFW = CW + 1;
   localparam int NODE_W = BYTE_W + CW;
   localparam logic [NFW-1:0] FIRST_CODE = NFW'(FIRST_LEARNED);
   localparam logic [NFW-1:0] DICT_LIMIT = NFW'(DICT_ENTRIES);

   lzwc_state_type state_ff, state_in;
   logic [BYTE_W-1:0]     byte_ff, byte_in;
   logic                  last_ff, last_in;
   logic [CW-1:0]         cur_ff, cur_in;
   logic [NFW-1:0]        next_free_ff, next_free_in;
   logic                  started_ff, started_in;
   logic [CW-1:0]         first_ff, first_in;
   logic [CW-1:0]         probe_ff, probe_in;
   logic [CW-1:0]         emit_code_ff, emit_code_in;
   logic [ROOT_CODES-1:0] root_vld_ff, root_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CODE_OUT_W-1:0] rsp_code_ff, rsp_code_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic              child_we, child_re;
   logic [CW-1:0]     child_waddr, child_wdata, child_raddr, child_rdata;
   logic              node_we, node_re;
   logic [CW-1:0]     node_waddr, node_raddr;
   logic [NODE_W-1:0] node_wdata, node_rdata;

   logic                  is_root, rsp_slot_free, dict_full;
   logic [CW-1:0]         child_code, node_sib;
   logic [BYTE_W-1:0]     node_byte;
   logic [CW+11:0]        emit_wide, cur_wide;
   logic [CODE_OUT_W-1:0] emit_out, cur_out;

   // first learned child of every code
   lzwc_ram #(.WIDTH(CW), .DEPTH(DICT_ENTRIES)) u_child_ram (
      .clock   (clock),
      .wr_en   (child_we),
      .wr_addr (child_waddr),
      .wr_data (child_wdata),
      .rd_en   (child_re),
      .rd_addr (child_raddr),
      .rd_data (child_rdata)
   );

   // learned code: its byte and next sibling
   lzwc_ram #(.WIDTH(NODE_W), .DEPTH(DICT_ENTRIES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_en   (node_re),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   // decode of current phrase and ram read data
   assign is_root = (cur_ff[CW-1:BYTE_W] == '0);
   assign child_code = (is_root && !root_vld_ff[cur_ff[BYTE_W-1:0]]) ? '0 : child_rdata;
   assign node_byte = node_rdata[NODE_W-1:CW];
   assign node_sib = node_rdata[CW-1:0];
   assign dict_full = (next_free_ff >= DICT_LIMIT);
   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;

   // codes as 12-bit words
   assign emit_wide = {12'b0, emit_code_ff};
   assign cur_wide = {12'b0, cur_ff};
   assign emit_out = emit_wide[CODE_OUT_W-1:0];
   assign cur_out = cur_wide[CODE_OUT_W-1:0];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cur_ff <= '0;
         next_free_ff <= FIRST_CODE;
         started_ff <= 1'b0;
         root_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         next_free_ff <= next_free_in;
         started_ff <= started_in;
         root_vld_ff <= root_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      first_ff <= first_in;
      probe_ff <= probe_in;
      emit_code_ff <= emit_code_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   // sequencer: trie walk, insert and code emission
   always_comb begin
      state_in = state_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      cur_in = cur_ff;
      next_free_in = next_free_ff;
      started_in = started_ff;
      first_in = first_ff;
      probe_in = probe_ff;
      emit_code_in = emit_code_ff;
      root_vld_in = root_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_code_in = rsp_code_ff;
      rsp_last_in = rsp_last_ff;
      req_ready = 1'b0;
      child_we = 1'b0;
      child_waddr = next_free_ff[CW-1:0];
      child_wdata = '0;
      child_re = 1'b0;
      child_raddr = cur_ff;
      node_we = 1'b0;
      node_waddr = next_free_ff[CW-1:0];
      node_wdata = {byte_ff, first_ff};
      node_re = 1'b0;
      node_raddr = node_sib;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               byte_in = req_data_byte;
               last_in = req_is_last_byte;
               if (!started_ff) begin
                  // first byte of a stream
                  cur_in = CW'(req_data_byte);
                  started_in = 1'b1;
                  state_in = req_is_last_byte ? S_EMIT_LAST : S_IDLE;
               end else if (dict_full) begin
                  // dictionary full: emit and start over
                  emit_code_in = cur_ff;
                  cur_in = CW'(req_data_byte);
                  next_free_in = FIRST_CODE;
                  root_vld_in = '0;
                  state_in = S_EMIT;
               end else begin
                  child_re = 1'b1;
                  state_in = S_CHILD;
               end
            end
         end
         S_CHILD: begin
            first_in = child_code;
            if (child_code == '0) begin
               // no children: learn the new node
               node_we = 1'b1;
               node_wdata = {byte_ff, child_code};
               child_we = 1'b1;
               state_in = S_INSERT;
            end else begin
               node_re = 1'b1;
               node_raddr = child_code;
               probe_in = child_code;
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            if (node_byte == byte_ff) begin
               // hit: extend the phrase
               cur_in = probe_ff;
               state_in = last_ff ? S_EMIT_LAST : S_IDLE;
            end else if (node_sib == '0) begin
               // end of sibling list: learn the new node
               node_we = 1'b1;
               child_we = 1'b1;
               state_in = S_INSERT;
            end else begin
               node_re = 1'b1;
               probe_in = node_sib;
            end
         end
         S_INSERT: begin
            // link the new node as first child of the phrase
            child_we = 1'b1;
            child_waddr = cur_ff;
            child_wdata = next_free_ff[CW-1:0];
            if (is_root) begin
               root_vld_in[cur_ff[BYTE_W-1:0]] = 1'b1;
            end
            emit_code_in = cur_ff;
            cur_in = CW'(byte_ff);
            next_free_in = next_free_ff + NFW'(1);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in = emit_out;
               rsp_last_in = 1'b0;
               state_in = last_ff ? S_EMIT_LAST : S_IDLE;
            end
         end
         S_EMIT_LAST: begin
            // closing code, then back to the reset dictionary
            if (rsp_slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in = cur_out;
               rsp_last_in = 1'b1;
               cur_in = '0;
               next_free_in = FIRST_CODE;
               started_in = 1'b0;
               root_vld_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_code = rsp_code_ff;
   assign rsp_is_last_code = rsp_last_ff;

   // checks
`include "lzw_byte_compressor_defines.svh"

   `LZWC_ASSERT(a_free_code_bound, clock, reset,
                next_free_ff <= DICT_LIMIT, "free code past table")
   `LZWC_ASSERT(a_cur_learned, clock, reset,
                started_ff |-> (NFW'(cur_ff) < next_free_ff), "phrase code not learned")
   `LZWC_ASSERT(a_probe_learned, clock, reset,
                (state_ff == S_NODE) |->
                   (NFW'(probe_ff) >= FIRST_CODE && NFW'(probe_ff) < next_free_ff),
                "probe outside learned codes")
   `LZWC_ASSERT_NEXT(a_restart_after_last, clock, reset,
                     state_ff == S_EMIT_LAST && rsp_slot_free,
                     !started_ff && next_free_ff == FIRST_CODE && rsp_valid && rsp_is_last_code,
                     "no restart after last code")

endmodule

/* rtl/core/lzwc_ram.sv */
module lzwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* dv/lzw_byte_compressor_checker.sv */
module lzw_byte_compressor_checker
   import lzwc_pkg::*;
#(
   parameter int DICT_ENTRIES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  logic                  req_is_last_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [CODE_OUT_W-1:0] rsp_out_code,
   input  logic                  rsp_is_last_code,
   output int                    fail_count,
   output int                    codes_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CODE_OUT_W-1:0] code;
      logic                  last;
   } emitted_code_type;

   // codes predicted but not yet seen on the response side
   emitted_code_type expected_codes[$];

   // learned phrases: key is {prefix code, byte}, value is the code
   int learned_codes[int];
   int phrase_code;
   int next_code;
   bit in_phrase;
   int errors;

   initial begin
      errors = 0;
   end

   function automatic void start_stream();
      learned_codes.delete();
      next_code = FIRST_LEARNED;
      phrase_code = 0;
      in_phrase = 0;
   endfunction

   function automatic void emit_code(int code, logic last);
      emitted_code_type c;
      c.code = CODE_OUT_W'(code);
      c.last = last;
      expected_codes = {expected_codes, c};
   endfunction

   // one byte through the compressor
   function automatic void compress_byte(logic [BYTE_W-1:0] b, logic is_last);
      int key;
      if (!in_phrase) begin
         phrase_code = b;
         in_phrase = 1;
      end else if (next_code >= DICT_ENTRIES) begin
         // dictionary full: flush the phrase and forget everything learned
         emit_code(phrase_code, 1'b0);
         learned_codes.delete();
         next_code = FIRST_LEARNED;
         phrase_code = b;
      end else begin
         key = ((phrase_code & 'hFFFF) << 8) | int'(b);
         if (learned_codes.exists(key)) begin
            phrase_code = learned_codes[key];
         end else begin
            emit_code(phrase_code, 1'b0);
            learned_codes[key] = next_code;
            next_code++;
            phrase_code = b;
         end
      end
      // end of stream closes the phrase and resets the dictionary
      if (is_last) begin
         emit_code(phrase_code, 1'b1);
         start_stream();
      end
   endfunction

   // predict on accepted requests, compare on accepted codes
   always @(posedge clock) begin
      emitted_code_type want;
      if (reset) begin
         start_stream();
         expected_codes.delete();
      end else begin
         if (req_valid && req_ready) begin
            compress_byte(req_data_byte, req_is_last_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               $error("out_code: expected none, actual %0d", rsp_out_code);
               errors++;
            end else begin
               want = expected_codes[0];
               expected_codes.delete(0);
               if (rsp_out_code !== want.code) begin
                  $error("out_code: expected %0d, actual %0d", want.code, rsp_out_code);
                  errors++;
               end
               if (rsp_is_last_code !== want.last) begin
                  $error("is_last_code: expected %0d, actual %0d", want.last,
                         rsp_is_last_code);
                  errors++;
               end
            end
         end
      end
      fail_count <= errors;
      codes_outstanding <= expected_codes.size();
   end

endmodule

/* dv/lzw_byte_compressor_test.sv */
module lzw_byte_compressor_test
   import lzwc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // small dictionary, so a full dictionary comes after a few hundred bytes
   localparam int DICT_ENTRIES = 512;
   localparam int RANDOM_BYTES = 260;
   localparam int TAIL_BYTES = 60;
   localparam int DRAIN_CYCLES = 300;
   localparam longint CYCLE_LIMIT = 10_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_data_byte = '0;
   logic                  req_is_last_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CODE_OUT_W-1:0] rsp_out_code;
   logic                  rsp_is_last_code;

   int     fail_count;
   int     codes_outstanding;
   longint cycle_count = 0;
   bit     send_gaps = 0;
   bit     recv_stalls = 0;
   int     bytes_sent = 0;

   always #10 clock = ~clock;

   lzw_byte_compressor #(
      .DICT_ENTRIES(DICT_ENTRIES)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_is_last_byte(req_is_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_code    (rsp_out_code),
      .rsp_is_last_code(rsp_is_last_code)
   );

   lzw_byte_compressor_checker #(
      .DICT_ENTRIES(DICT_ENTRIES)
   ) code_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_is_last_byte (req_is_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_code     (rsp_out_code),
      .rsp_is_last_code (rsp_is_last_code),
      .fail_count       (fail_count),
      .codes_outstanding(codes_outstanding)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lzw_byte_compressor: mismatch");
         $finish;
      end
   end

   // response side back-pressure in bursts
   initial begin
      wait (!reset);
      @(negedge clock);
      forever begin
         if (recv_stalls && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // one request, optionally after a gap; returns at the next falling edge
   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic is_last);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_is_last_byte <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // random stream: uniform bytes, a narrow alphabet, or a repeated pattern
   task automatic feed_stream(input int len);
      int                mode;
      int                plen;
      logic [BYTE_W-1:0] base;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] pattern[8];
      mode = $urandom_range(0, 2);
      base = BYTE_W'($urandom);
      plen = $urandom_range(1, 6);
      for (int i = 0; i < 8; i++) pattern[i] = base + BYTE_W'($urandom_range(0, 3));
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: b = BYTE_W'($urandom);
            1: b = base + BYTE_W'($urandom_range(0, 3));
            default: b = ($urandom_range(0, 15) == 0) ? BYTE_W'($urandom) : pattern[i % plen];
         endcase
         push_byte(b, i == len - 1);
      end
   endtask

   // every byte pair distinct, so each byte after the first learns a code;
   // odd strides walk all 256 values and come back to the start
   task automatic fill_dictionary(input bit last_on_full);
      logic [BYTE_W-1:0] offset;
      logic [BYTE_W-1:0] walk;
      offset = BYTE_W'($urandom);
      walk = '0;
      push_byte(offset, 1'b0);
      for (int d = 1; d < 2 * ((DICT_ENTRIES - FIRST_LEARNED) / 256); d += 2) begin
         for (int i = 0; i < 256; i++) begin
            walk += BYTE_W'(d);
            push_byte(walk + offset, 1'b0);
         end
      end
      // dictionary is full now
      push_byte(BYTE_W'($urandom), last_on_full);
      if (!last_on_full) begin
         for (int i = 0; i < 20; i++) push_byte(BYTE_W'($urandom), i == 19);
      end
   endtask

   initial begin
      int target;
      int len;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: single-byte streams at the extremes, runs that extend phrases
      send_gaps = 1;
      recv_stalls = 1;
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      for (int i = 0; i < 6; i++) push_byte(8'h00, i == 5);
      for (int i = 0; i < 7; i++) push_byte((i == 3) ? 8'h00 : 8'hFF, i == 6);
      for (int i = 0; i < 8; i++) push_byte(i[0] ? 8'hAA : 8'h55, i == 7);

      // full dictionary in mid stream
      fill_dictionary(1'b0);

      // random streams, idling switched per stream
      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         send_gaps = $urandom_range(0, 3) != 0;
         recv_stalls = $urandom_range(0, 3) != 0;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
         feed_stream(len);
      end

      // full dictionary on the last byte
      fill_dictionary(1'b1);

      // closing stretch without idling
      send_gaps = 0;
      recv_stalls = 0;
      target = bytes_sent + TAIL_BYTES;
      while (bytes_sent < target) feed_stream($urandom_range(1, 20));
      req_valid <= 1'b0;

      while (codes_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("lzw_byte_compressor: match");
      end else begin
         $display("lzw_byte_compressor: mismatch");
      end
      $finish;
   end

endmodule
